@@ rtl/modular_exponentiation_defines.svh @@
// Assertion macros shared by the modular exponentiation RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MEXP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mexp_pkg.sv @@
// Shared types and constants for the modular exponentiation block.
// Depends on nothing; imported by mexp_mulmod and modular_exponentiation.
package mexp_pkg;

  // Operand, modulus and result width
  localparam int VAL_W       = 31;
  // Exponent port width and number of exponent bits scanned
  localparam int EXP_W       = 63;
  localparam int EXP_BITS    = 63;
  localparam int EXP_CNT_W   = $clog2(EXP_BITS + 1);
  // One multiplier bit per step in the modular multiply unit
  localparam int MUL_CNT_W   = $clog2(VAL_W);

  localparam logic [VAL_W-1:0] MODULUS_RESET = VAL_W'(1000000007);
  localparam logic [VAL_W-1:0] VAL_ONE       = VAL_W'(1);
  localparam logic [VAL_W-1:0] VAL_TWO       = VAL_W'(2);

  // Request to the modular multiply unit
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } mexp_mul_req_t;

  // Status back from the modular multiply unit
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [VAL_W-1:0] result;
  } mexp_mul_rsp_t;

endpackage

@@ rtl/modular_exponentiation.sv @@
// Modular exponentiation by square-and-multiply over a configured modulus.
// Channels: in_valid/in_stall carry a word of in_base_value and in_exponent;
// out_valid/out_stall carry a word of out_power_result. cfg_valid/cfg_ready
// write cfg_modulus (reset value 1000000007); write it only while idle.
// Operation: the base is first reduced. The exponent is then scanned from its
// top bit; leading zero bits are skipped with no product. The leading one
// copies the base into the accumulator; each later bit costs a squaring, plus
// a multiply when the bit is set, each in the shared 31-step modular multiply
// unit. A modulus of 0 or 1 returns 0 without using the multiply unit.
// Throughput: one word at a time; in_stall is high from the accepted word
// until its result is placed in the output register. The output register
// frees the input side: a new word is taken while a result waits.
// When the receiver stalls, out_valid and out_power_result hold, and a
// finished computation waits until the output register is free.
// Reset (rst_n low at a clock edge) empties both sides and restores the
// modulus to its reset value.
// Depends on mexp_pkg, mexp_mulmod and modular_exponentiation_defines.svh.
`include "modular_exponentiation_defines.svh"

module modular_exponentiation
  import mexp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // configuration write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VAL_W-1:0] cfg_modulus,
  // input words
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [VAL_W-1:0] in_base_value,
  input  logic [EXP_W-1:0] in_exponent,
  // result words
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] out_power_result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_SQR,
    ST_MUL,
    ST_FINISH
  } state_t;

  state_t                state_r;
  logic [VAL_W-1:0]      modulus_r;
  logic [VAL_W-1:0]      base_r;
  logic [VAL_W-1:0]      acc_r;
  logic [EXP_BITS-1:0]   exp_r;
  logic [EXP_CNT_W-1:0]  cnt_r;
  logic                  started_r;
  logic                  out_valid_r;
  logic [VAL_W-1:0]      out_result_r;
  mexp_mul_req_t         mul_req_r;
  mexp_mul_rsp_t         mul_rsp;

  logic                  in_take;
  logic                  out_free;
  logic                  out_load;
  logic                  mul_issue;
  logic                  last_bit;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_FINISH) && out_free;
  assign last_bit = (cnt_r == EXP_CNT_W'(1));

  // Issue a product: base reduction, a squaring, or a multiply on a set bit
  assign mul_issue = (state_r == ST_IDLE && in_take && modulus_r >= VAL_TWO) ||
                     (state_r == ST_SCAN && started_r) ||
                     (state_r == ST_SQR && mul_rsp.done && exp_r[EXP_BITS-1]);

  // Hold the modulus register; writes are always taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
    end else if (cfg_valid) begin
      modulus_r <= cfg_modulus;
    end
  end

  assign cfg_ready = 1'b1;

  // Shared modular multiply unit
  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (modulus_r),
    .req     (mul_req_r),
    .rsp     (mul_rsp)
  );

  // Sequencer: reduce the base, scan exponent bits, square and multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      started_r       <= 1'b0;
      mul_req_r.start <= 1'b0;
    end else begin
      mul_req_r.start <= mul_issue;
      out_valid_r     <= out_load || (out_valid_r && out_stall);
      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            exp_r     <= in_exponent[EXP_BITS-1:0];
            cnt_r     <= EXP_CNT_W'(EXP_BITS);
            started_r <= 1'b0;
            if (modulus_r < VAL_TWO) begin
              acc_r   <= '0;
              state_r <= ST_FINISH;
            end else begin
              // base mod m computed as 1 * base through the multiply unit
              mul_req_r.a     <= VAL_ONE;
              mul_req_r.b     <= in_base_value;
              state_r         <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mul_rsp.done) begin
            base_r  <= mul_rsp.result;
            acc_r   <= VAL_ONE;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (started_r) begin
            mul_req_r.a     <= acc_r;
            mul_req_r.b     <= acc_r;
            state_r         <= ST_SQR;
          end else begin
            // accumulator is still one: squaring is a no-op, multiply is a copy
            if (exp_r[EXP_BITS-1]) begin
              acc_r     <= base_r;
              started_r <= 1'b1;
            end
            exp_r <= exp_r << 1;
            cnt_r <= cnt_r - 1'b1;
            if (last_bit) begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_SQR: begin
          if (mul_rsp.done) begin
            acc_r <= mul_rsp.result;
            if (exp_r[EXP_BITS-1]) begin
              mul_req_r.a     <= mul_rsp.result;
              mul_req_r.b     <= base_r;
              state_r         <= ST_MUL;
            end else begin
              exp_r   <= exp_r << 1;
              cnt_r   <= cnt_r - 1'b1;
              state_r <= last_bit ? ST_FINISH : ST_SCAN;
            end
          end
        end
        ST_MUL: begin
          if (mul_rsp.done) begin
            acc_r   <= mul_rsp.result;
            exp_r   <= exp_r << 1;
            cnt_r   <= cnt_r - 1'b1;
            state_r <= last_bit ? ST_FINISH : ST_SCAN;
          end
        end
        ST_FINISH: begin
          // load the output register once it is free
          if (out_free) begin
            out_result_r <= acc_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_result_r;

  `MEXP_ASSERT_NEXT(a_take_stalls, clk, rst_n, in_take, in_stall, "input open during a word")
  `MEXP_ASSERT_NOW(a_done_waiting, clk, rst_n, mul_rsp.done, state_r == ST_REDUCE || state_r == ST_SQR || state_r == ST_MUL, "product with no waiter")
  `MEXP_ASSERT_NOW(a_start_free, clk, rst_n, mul_req_r.start, !mul_rsp.busy && !mul_rsp.done, "multiply issued while unit busy")

endmodule

@@ rtl/mexp_mulmod.sv @@
// Iterative modular multiplier: (a * b) mod m, one bit of b per cycle.
// Depends on mexp_pkg and modular_exponentiation_defines.svh.
`include "modular_exponentiation_defines.svh"

module mexp_mulmod
  import mexp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [VAL_W-1:0] modulus,
  input  mexp_mul_req_t    req,
  output mexp_mul_rsp_t    rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [VAL_W-1:0]     acc_r;
  logic [VAL_W-1:0]     a_r;
  logic [VAL_W-1:0]     b_r;
  logic [VAL_W-1:0]     m_r;

  logic [VAL_W+2:0]     sum;
  logic [VAL_W+2:0]     diff1;
  logic [VAL_W+2:0]     diff2;
  logic [VAL_W-1:0]     acc_nxt;

  // Double the partial result, add a on a set bit of b, fold back below m.
  // a < m and acc < m keep the sum below 3m, so one of three picks is right.
  always_comb begin
    sum   = {2'b00, acc_r, 1'b0} + {3'b000, (b_r[VAL_W-1] ? a_r : {VAL_W{1'b0}})};
    diff1 = sum - {3'b000, m_r};
    diff2 = sum - {2'b00, m_r, 1'b0};
    if (!diff2[VAL_W+2]) begin
      acc_nxt = diff2[VAL_W-1:0];
    end else if (!diff1[VAL_W+2]) begin
      acc_nxt = diff1[VAL_W-1:0];
    end else begin
      acc_nxt = sum[VAL_W-1:0];
    end
  end

  // Step sequencer: latch operands on start, run one step per multiplier bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (busy_r) begin
        acc_r <= acc_nxt;
        b_r   <= {b_r[VAL_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= MUL_CNT_W'(VAL_W - 1);
        acc_r  <= '0;
        a_r    <= req.a;
        b_r    <= req.b;
        m_r    <= modulus;
      end
    end
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

  `MEXP_ASSERT_NEXT(a_start_busy, clk, rst_n, req.start && !busy_r, busy_r, "start not taken")
  `MEXP_ASSERT_NEXT(a_last_done, clk, rst_n, busy_r && cnt_r == '0, done_r && !busy_r, "no done after last step")
  `MEXP_ASSERT_NOW(a_done_idle, clk, rst_n, done_r, !busy_r, "done while still stepping")

endmodule
